// ===== rtl/dktl_pkg.sv =====
// shared types, constants and hash function for the device key table
package dktl_pkg;

   // sizes
   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam int MAP_SLOTS           = 256;
   localparam int SLOT_BITS           = 8;
   localparam int SLOT_ENTRY_BITS     = 7;
   localparam int KEY_BITS            = 24;
   localparam int MISS_BITS           = 8;

   // miss count limits
   localparam logic [MISS_BITS-1:0] MISS_MAX        = 8'hFF;
   localparam logic [MISS_BITS-1:0] THRESHOLD_RESET = 8'd3;

   // hash weights of the two sub-address bytes
   localparam int HASH_MUL_FIRST  = 3;
   localparam int HASH_MUL_SECOND = 7;

   // register port
   localparam int   CSR_ADDR_BITS     = 3;
   localparam int   CSR_DATA_BITS     = 32;
   localparam logic CSR_REG_THRESHOLD = 1'b0;

   typedef enum logic [1:0] {
      CMD_FIND  = 2'd0,
      CMD_ACK   = 2'd1,
      CMD_POLL  = 2'd2,
      CMD_CLEAR = 2'd3
   } command_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [MISS_BITS-1:0] misses;
      logic                 online;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      tally_inc;
      logic      tally_dec;
   } apply_type;

   // home slot: (id + 3*s1 + 7*s2) mod 256
   function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [7:0] id,
                                                     input logic [7:0] s1,
                                                     input logic [7:0] s2);
      logic [SLOT_BITS-1:0] t1;
      logic [SLOT_BITS-1:0] t2;
      t1 = SLOT_BITS'(s1 * HASH_MUL_FIRST);
      t2 = SLOT_BITS'(s2 * HASH_MUL_SECOND);
      return SLOT_BITS'(id + t1 + t2);
   endfunction

endpackage

// ===== rtl/dktl_ram.sv =====
// generic single-write, single-read RAM with registered read data
module dktl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/dktl_apply.sv =====
// per-command update of one entry's miss count and online flag
module dktl_apply (
   input  dktl_pkg::command_type      cmd,
   input  dktl_pkg::entry_type        cur,
   input  logic [dktl_pkg::MISS_BITS-1:0] threshold,
   output dktl_pkg::apply_type        res
);
   import dktl_pkg::*;

   // acknowledgement clears misses and goes online, a poll counts up (saturating) and goes offline at the threshold
   always_comb begin
      res.entry     = cur;
      res.tally_inc = 1'b0;
      res.tally_dec = 1'b0;
      unique case (cmd)
         CMD_ACK: begin
            res.entry.misses = '0;
            if (!cur.online) begin
               res.entry.online = 1'b1;
               res.tally_inc    = 1'b1;
            end
         end
         CMD_POLL: begin
            if (cur.misses != MISS_MAX) begin
               res.entry.misses = cur.misses + 1'b1;
            end
            if (res.entry.misses >= threshold && cur.online) begin
               res.entry.online = 1'b0;
               res.tally_dec    = 1'b1;
            end
         end
         default: begin
            res.entry = cur;
         end
      endcase
   end
endmodule

// ===== rtl/device_key_table_with_liveness.sv =====
// top level: device key table with hashed slot map, probe sequencer and liveness
//
// Commands enter on the req_ ports and are taken when start is high and busy
// is low. Each command gives exactly one result on the rsp_ ports, shown for
// one cycle with rsp_strobe high; the receiver cannot stall the result.
// A clear command is handled in idle and its result follows in the next cycle.
// Other commands walk the slot map from the key's home slot with one shared
// probe path: an occupied slot goes through slot map read, entry store read
// and key compare. After the walk an update state writes the entry (not for a
// find or a refused append) and registers the result, which appears in the
// cycle after it. The walk ends on an empty slot, on the matching key or
// after MAX_ENTRIES slots. busy is high from the transfer until the update is
// done, and the next command can be taken in the cycle that shows the result.
// The threshold register is written over the APB-style port; the user must
// write it only while busy is low, as the block itself does not enforce this.
// Reset empties the table at once (a valid bit per map slot), clears the entry
// and online counts and sets the threshold to 3.
module device_key_table_with_liveness #(
   parameter int MAX_ENTRIES = dktl_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_command,
   input  logic [7:0]                           req_device_id,
   input  logic [7:0]                           req_sub_first,
   input  logic [7:0]                           req_sub_second,
   // result channel
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic                                 rsp_newly_created,
   output logic                                 rsp_table_full,
   output logic [5:0]                           rsp_entry_index,
   output logic [7:0]                           rsp_miss_count,
   output logic                                 rsp_online,
   output logic [6:0]                           rsp_online_total,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dktl_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dktl_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dktl_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import dktl_pkg::*;

   localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_ENTRY,
      ST_CMP,
      ST_UPDATE
   } state_type;

   state_type                  state_ff;
   logic [MAP_SLOTS-1:0]       slot_valid_ff;
   logic [CNT_W-1:0]           used_ff;
   logic [CNT_W-1:0]           tally_ff;
   logic [CNT_W-1:0]           tally_in;
   logic [CNT_W-1:0]           probe_cnt_ff;
   logic [SLOT_BITS-1:0]       probe_slot_ff;
   command_type                cmd_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic [ENTRY_AW-1:0]        idx_ff;
   logic                       found_ff;
   entry_type                  cur_ff;
   logic [MISS_BITS-1:0]       threshold_ff;

   logic                       rsp_strobe_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_created_ff;
   logic                       rsp_full_ff;
   logic [5:0]                 rsp_index_ff;
   logic [7:0]                 rsp_misses_ff;
   logic                       rsp_online_ff;
   logic [6:0]                 rsp_total_ff;

   logic [SLOT_ENTRY_BITS-1:0] slot_rdata;
   logic                       slot_we;
   entry_type                  entry_rdata;
   entry_type                  entry_wdata;
   entry_type                  base_entry;
   logic                       entry_we;
   logic [ENTRY_AW-1:0]        entry_waddr;
   logic [ENTRY_AW-1:0]        entry_raddr;
   logic [ENTRY_AW-1:0]        new_idx;
   logic                       create;
   logic                       slot_live;
   apply_type                  upd;

   // slot map: entry number per slot
   dktl_ram #(
      .WIDTH(SLOT_ENTRY_BITS),
      .DEPTH(MAP_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(probe_slot_ff),
      .wr_data(SLOT_ENTRY_BITS'(used_ff)),
      .rd_addr(probe_slot_ff),
      .rd_data(slot_rdata)
   );

   // entry store: key, miss count, online flag
   dktl_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (entry_we),
      .wr_addr(entry_waddr),
      .wr_data(entry_wdata),
      .rd_addr(entry_raddr),
      .rd_data(entry_rdata)
   );

   // command update on the found or freshly created entry
   dktl_apply u_apply (
      .cmd      (cmd_ff),
      .cur      (base_entry),
      .threshold(threshold_ff),
      .res      (upd)
   );

   // probe and update datapath
   always_comb begin
      new_idx     = ENTRY_AW'(used_ff);
      create      = !found_ff && (cmd_ff != CMD_FIND) && (used_ff < CNT_FULL);
      slot_live   = slot_rdata < SLOT_ENTRY_BITS'(used_ff);
      base_entry  = found_ff ? cur_ff : entry_type'{key: key_ff, misses: '0, online: 1'b0};
      entry_wdata = upd.entry;
      entry_waddr = found_ff ? idx_ff : new_idx;
      entry_we    = (state_ff == ST_UPDATE) &&
                    (found_ff ? (cmd_ff != CMD_FIND) : create);
      slot_we     = (state_ff == ST_UPDATE) && create;
      entry_raddr = (state_ff == ST_ENTRY) ? ENTRY_AW'(slot_rdata) : idx_ff;
      tally_in    = tally_ff;
      if (found_ff || create) begin
         if (upd.tally_inc) begin
            tally_in = tally_ff + 1'b1;
         end else if (upd.tally_dec && tally_ff != '0) begin
            tally_in = tally_ff - 1'b1;
         end
      end
   end

   // sequencer with registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         used_ff       <= '0;
         tally_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               // only a clear answers straight from idle
               rsp_strobe_ff <= start && (command_type'(req_command) == CMD_CLEAR);
               if (start) begin
                  cmd_ff        <= command_type'(req_command);
                  key_ff        <= {req_device_id, req_sub_first, req_sub_second};
                  probe_slot_ff <= hash_slot(req_device_id, req_sub_first, req_sub_second);
                  probe_cnt_ff  <= '0;
                  if (command_type'(req_command) == CMD_CLEAR) begin
                     slot_valid_ff  <= '0;
                     used_ff        <= '0;
                     tally_ff       <= '0;
                     rsp_hit_ff     <= 1'b0;
                     rsp_created_ff <= 1'b0;
                     rsp_full_ff    <= 1'b0;
                     rsp_index_ff   <= '0;
                     rsp_misses_ff  <= '0;
                     rsp_online_ff  <= 1'b0;
                     rsp_total_ff   <= '0;
                  end else begin
                     state_ff <= ST_SLOT;
                  end
               end
            end
            ST_SLOT: begin
               rsp_strobe_ff <= 1'b0;
               // empty slot ends the walk and is the append slot
               if (!slot_valid_ff[probe_slot_ff]) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_UPDATE;
               end else begin
                  state_ff <= ST_ENTRY;
               end
            end
            ST_ENTRY: begin
               rsp_strobe_ff <= 1'b0;
               if (slot_live) begin
                  idx_ff   <= ENTRY_AW'(slot_rdata);
                  state_ff <= ST_CMP;
               end else if (probe_cnt_ff == CNT_LAST) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_UPDATE;
               end else begin
                  probe_slot_ff <= probe_slot_ff + 1'b1;
                  probe_cnt_ff  <= probe_cnt_ff + 1'b1;
                  state_ff      <= ST_SLOT;
               end
            end
            ST_CMP: begin
               rsp_strobe_ff <= 1'b0;
               if (entry_rdata.key == key_ff) begin
                  found_ff <= 1'b1;
                  cur_ff   <= entry_rdata;
                  state_ff <= ST_UPDATE;
               end else if (probe_cnt_ff == CNT_LAST) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_UPDATE;
               end else begin
                  probe_slot_ff <= probe_slot_ff + 1'b1;
                  probe_cnt_ff  <= probe_cnt_ff + 1'b1;
                  state_ff      <= ST_SLOT;
               end
            end
            ST_UPDATE: begin
               tally_ff       <= tally_in;
               rsp_strobe_ff  <= 1'b1;
               rsp_total_ff   <= 7'(tally_in);
               rsp_created_ff <= create;
               rsp_full_ff    <= !found_ff && !create && (cmd_ff != CMD_FIND);
               if (create) begin
                  slot_valid_ff[probe_slot_ff] <= 1'b1;
                  used_ff                      <= used_ff + 1'b1;
               end
               if (found_ff || create) begin
                  rsp_hit_ff    <= 1'b1;
                  rsp_index_ff  <= 6'(entry_waddr);
                  rsp_misses_ff <= upd.entry.misses;
                  rsp_online_ff <= upd.entry.online;
               end else begin
                  rsp_hit_ff    <= 1'b0;
                  rsp_index_ff  <= '0;
                  rsp_misses_ff <= '0;
                  rsp_online_ff <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (psel && penable && pwrite &&
                   paddr[CSR_ADDR_BITS-1] == CSR_REG_THRESHOLD) begin
         threshold_ff <= pwdata[MISS_BITS-1:0];
      end
   end

   // register reads
   assign prdata = (paddr[CSR_ADDR_BITS-1] == CSR_REG_THRESHOLD) ?
                   CSR_DATA_BITS'(threshold_ff) : '0;
   assign pready = 1'b1;

   // ports
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_newly_created = rsp_created_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_miss_count    = rsp_misses_ff;
   assign rsp_online        = rsp_online_ff;
   assign rsp_online_total  = rsp_total_ff;
endmodule

// ===== bench/device_key_table_with_liveness_tb.sv =====
// testbench for the device key table: directed table, then random phases checked by a predictor
module device_key_table_with_liveness_tb;
   import dktl_pkg::*;

   localparam int TABLE_DEPTH   = DEFAULT_MAX_ENTRIES;
   localparam int HALF_PERIOD   = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 250;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 15;
   localparam logic [CSR_ADDR_BITS-1:0] THRESHOLD_ADDR =
      CSR_ADDR_BITS'(4 * int'(CSR_REG_THRESHOLD));

   typedef enum {PHASE_FILL, PHASE_SATURATE, PHASE_MIXED, PHASE_NOISE} phase_kind_type;

   typedef struct packed {
      logic       hit;
      logic       created;
      logic       full;
      logic [5:0] index;
      logic [7:0] misses;
      logic       online;
      logic [6:0] total;
   } table_status_type;

   typedef struct {
      command_type      cmd;
      logic [7:0]       id;
      logic [7:0]       s1;
      logic [7:0]       s2;
      bit               typed;
      table_status_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_FIND;
   logic [7:0] req_device_id = 8'h00;
   logic [7:0] req_sub_first = 8'h00;
   logic [7:0] req_sub_second = 8'h00;
   logic rsp_strobe, rsp_hit, rsp_newly_created, rsp_table_full, rsp_online;
   logic [5:0] rsp_entry_index;
   logic [7:0] rsp_miss_count;
   logic [6:0] rsp_online_total;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor state
   bit          slot_used[MAP_SLOTS];
   logic [6:0]  slot_entry[MAP_SLOTS];
   logic [23:0] key_store[TABLE_DEPTH];
   logic [7:0]  miss_store[TABLE_DEPTH];
   bit          online_store[TABLE_DEPTH];
   int          used_count = 0;
   int          live_count = 0;
   logic [7:0]  threshold_shadow = THRESHOLD_RESET;

   // expected results, oldest first
   table_status_type expected_status[$];
   table_status_type seen_status;
   table_status_type wanted_status;

   int mismatch_count = 0;
   int results_checked = 0;
   int commands_sent = 0;
   int creates_seen = 0;
   int refusals_seen = 0;
   int clears_seen = 0;
   int saturations_seen = 0;
   int threshold_writes = 0;
   int stall_cycles = 0;

   device_key_table_with_liveness DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_device_id(req_device_id),
      .req_sub_first(req_sub_first),
      .req_sub_second(req_sub_second),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_newly_created(rsp_newly_created),
      .rsp_table_full(rsp_table_full),
      .rsp_entry_index(rsp_entry_index),
      .rsp_miss_count(rsp_miss_count),
      .rsp_online(rsp_online),
      .rsp_online_total(rsp_online_total),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // table behavior: probe from the home slot, append on a miss, update liveness
   function automatic table_status_type apply_command(command_type cmd, logic [7:0] id,
                                                      logic [7:0] s1, logic [7:0] s2);
      logic [23:0]      key;
      logic [7:0]       home;
      logic [7:0]       probe;
      int               found;
      int               idx;
      table_status_type res;
      key = {id, s1, s2};
      home = 8'(int'(id) + 3 * int'(s1) + 7 * int'(s2));
      res = '0;
      found = -1;
      if (cmd == CMD_CLEAR) begin
         for (int i = 0; i < MAP_SLOTS; i++) slot_used[i] = 1'b0;
         used_count = 0;
         live_count = 0;
         clears_seen++;
         return res;
      end
      // lookup stops at an empty slot or after one slot per possible entry
      probe = home;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         if (!slot_used[probe]) break;
         idx = int'(slot_entry[probe]);
         if (idx < used_count && idx < TABLE_DEPTH && key_store[idx] == key) begin
            found = idx;
            break;
         end
         probe++;
      end
      // append into the first free slot from home
      if (found < 0 && cmd != CMD_FIND) begin
         if (used_count < TABLE_DEPTH) begin
            found = used_count;
            used_count++;
            key_store[found] = key;
            miss_store[found] = 8'h00;
            online_store[found] = 1'b0;
            probe = home;
            for (int n = 0; n < MAP_SLOTS; n++) begin
               if (!slot_used[probe]) begin
                  slot_used[probe] = 1'b1;
                  slot_entry[probe] = 7'(found);
                  break;
               end
               probe++;
            end
            res.created = 1'b1;
            creates_seen++;
         end else begin
            res.full = 1'b1;
            refusals_seen++;
         end
      end
      if (found >= 0) begin
         if (cmd == CMD_ACK) begin
            miss_store[found] = 8'h00;
            if (!online_store[found]) begin
               online_store[found] = 1'b1;
               live_count++;
            end
         end else if (cmd == CMD_POLL) begin
            if (miss_store[found] != 8'hFF) miss_store[found]++;
            if (miss_store[found] >= threshold_shadow && online_store[found]) begin
               online_store[found] = 1'b0;
               if (live_count > 0) live_count--;
            end
         end
         res.hit = 1'b1;
         res.index = 6'(found);
         res.misses = miss_store[found];
         res.online = online_store[found];
         if (res.misses == 8'hFF) saturations_seen++;
      end
      res.total = 7'(live_count);
      return res;
   endfunction

   // sender gap: mostly short, a few long, none in a burst
   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_status(string what, table_status_type want, table_status_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s at %0t: expected hit=%0d new=%0d full=%0d idx=%0d miss=%0d on=%0d tot=%0d",
                  what, $time, want.hit, want.created, want.full, want.index, want.misses,
                  want.online, want.total);
         $display("   got hit=%0d new=%0d full=%0d idx=%0d miss=%0d on=%0d tot=%0d",
                  got.hit, got.created, got.full, got.index, got.misses, got.online,
                  got.total);
      end
   endtask

   // one command transfer; the prediction is taken when the block accepts it
   task automatic send_command(command_type cmd, logic [7:0] id, logic [7:0] s1,
                               logic [7:0] s2, int gap, bit typed,
                               table_status_type typed_want);
      table_status_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_device_id <= id;
      req_sub_first <= s1;
      req_sub_second <= s2;
      do @(posedge clock); while (busy);
      predicted = apply_command(cmd, id, s1, s2);
      expected_status.push_back(typed ? typed_want : predicted);
      commands_sent++;
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_status.size() != 0 || busy) @(posedge clock);
   endtask

   // threshold write followed by a read back
   task automatic write_threshold(logic [7:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= THRESHOLD_ADDR;
      pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      threshold_shadow = value;
      threshold_writes++;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_BITS'(value)) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("threshold read back at %0t: expected %0d got %0d", $time, value, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_status = {rsp_hit, rsp_newly_created, rsp_table_full, rsp_entry_index,
                        rsp_miss_count, rsp_online, rsp_online_total};
         results_checked++;
         if (expected_status.size() == 0) begin
            report_status("unexpected result", '0, seen_status);
         end else begin
            wanted_status = expected_status.pop_front();
            if (seen_status.hit !== wanted_status.hit ||
                seen_status.created !== wanted_status.created ||
                seen_status.full !== wanted_status.full ||
                seen_status.index !== wanted_status.index ||
                seen_status.misses !== wanted_status.misses ||
                seen_status.online !== wanted_status.online ||
                seen_status.total !== wanted_status.total)
               report_status("result mismatch", wanted_status, seen_status);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type   directed_rows[DIRECTED_ROWS];
      int             phase;
      int             items_in_phase;
      int             pool_size;
      int             home_count;
      int             r;
      phase_kind_type kind;
      bit             burst;
      logic [7:0]     thr;
      logic [7:0]     homes[3];
      logic [23:0]    pool[$];
      logic [23:0]    key;
      logic [7:0]     cid;
      logic [7:0]     cs1;
      logic [7:0]     cs2;
      command_type    cmd;

      // directed: keys at the byte extremes, liveness at the reset threshold,
      // probing past a shared home slot, clear and lookups after it
      directed_rows = '{
         '{CMD_FIND, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd0, 8'd0, 1'b0, 7'd0}},
         '{CMD_ACK, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 6'd0, 8'd0, 1'b1, 7'd1}},
         '{CMD_POLL, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd0, 8'd1, 1'b1, 7'd1}},
         '{CMD_POLL, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd0, 8'd2, 1'b1, 7'd1}},
         '{CMD_POLL, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd0, 8'd3, 1'b0, 7'd0}},
         '{CMD_ACK, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd0, 8'd0, 1'b1, 7'd1}},
         '{CMD_POLL, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 6'd1, 8'd1, 1'b0, 7'd1}},
         '{CMD_ACK, 8'hFD, 8'h01, 8'h00, 1'b0, '0},
         '{CMD_FIND, 8'hFD, 8'h01, 8'h00, 1'b0, '0},
         '{CMD_FIND, 8'hF9, 8'h00, 8'h01, 1'b0, '0},
         '{CMD_POLL, 8'hF9, 8'h00, 8'h01, 1'b0, '0},
         '{CMD_CLEAR, 8'hAA, 8'h55, 8'hAA, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd0, 8'd0, 1'b0, 7'd0}},
         '{CMD_FIND, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd0, 8'd0, 1'b0, 7'd0}},
         '{CMD_ACK, 8'h55, 8'hAA, 8'h55, 1'b1, '{1'b1, 1'b1, 1'b0, 6'd0, 8'd0, 1'b1, 7'd1}},
         '{CMD_FIND, 8'h00, 8'hFF, 8'h00, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].s1,
                      directed_rows[i].s2, pick_gap(1'b0), directed_rows[i].typed,
                      directed_rows[i].want);

      // random phases, each with its own threshold and key pool
      phase = 0;
      while (commands_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         wait_for_drain();
         if (phase < 4) kind = phase_kind_type'(phase);
         else begin
            r = $urandom_range(0, 99);
            kind = (r < 45) ? PHASE_MIXED : (r < 70) ? PHASE_FILL :
                   (r < 80) ? PHASE_SATURATE : PHASE_NOISE;
         end
         case (phase)
            0: thr = 8'd1;
            1: thr = 8'd255;
            2: thr = 8'd0;
            default: thr = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(1, 6))
                                                         : 8'($urandom_range(1, 255));
         endcase
         write_threshold(thr);

         // key pool: about half of it crowds one to three home slots, the first two neighboring
         case (kind)
            PHASE_FILL:     pool_size = $urandom_range(70, 90);
            PHASE_SATURATE: pool_size = 1;
            PHASE_MIXED:    pool_size = $urandom_range(4, 24);
            default:        pool_size = $urandom_range(8, 32);
         endcase
         home_count = $urandom_range(1, 3);
         homes[0] = 8'($urandom);
         homes[1] = homes[0] + 8'd1;
         homes[2] = 8'($urandom);
         pool.delete();
         repeat (pool_size) begin
            r = $urandom_range(0, 99);
            cs1 = 8'($urandom);
            cs2 = 8'($urandom);
            cid = 8'($urandom);
            if (r < 50)
               cid = 8'(int'(homes[$urandom_range(0, home_count - 1)]) - 3 * int'(cs1)
                        - 7 * int'(cs2));
            else if (r < 56)
               {cid, cs1, cs2} = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
            pool.push_back({cid, cs1, cs2});
         end

         case (kind)
            PHASE_FILL:     items_in_phase = $urandom_range(160, 240);
            PHASE_SATURATE: items_in_phase = 290;
            PHASE_MIXED:    items_in_phase = $urandom_range(60, 200);
            default:        items_in_phase = $urandom_range(40, 100);
         endcase
         burst = ($urandom_range(0, 4) == 0);

         if (kind != PHASE_SATURATE && $urandom_range(0, 1) != 0)
            send_command(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                         pick_gap(burst), 1'b0, '0);

         for (int item = 0; item < items_in_phase &&
              commands_sent < DIRECTED_ROWS + RANDOM_ITEMS; item++) begin
            r = $urandom_range(0, 99);
            case (kind)
               PHASE_FILL:
                  cmd = (r < 45) ? CMD_ACK : (r < 85) ? CMD_POLL : (r < 99) ? CMD_FIND : CMD_CLEAR;
               PHASE_SATURATE:
                  cmd = (item == 0) ? CMD_ACK : (r < 90) ? CMD_POLL : CMD_FIND;
               PHASE_MIXED:
                  cmd = (r < 35) ? CMD_ACK : (r < 75) ? CMD_POLL : (r < 98) ? CMD_FIND : CMD_CLEAR;
               default:
                  cmd = (r < 4) ? CMD_CLEAR : command_type'($urandom_range(0, 2));
            endcase
            r = $urandom_range(0, 99);
            if ((kind == PHASE_NOISE && r < 80) || (kind != PHASE_SATURATE && r < 8))
               key = 24'($urandom);
            else
               key = pool[$urandom_range(0, pool.size() - 1)];
            send_command(cmd, key[23:16], key[15:8], key[7:0], pick_gap(burst), 1'b0, '0);
            // now and then wait until every expected result has come back before going on
            if ($urandom_range(0, 59) == 0) wait_for_drain();
         end
         phase++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d commands, %0d thresholds: %0d appends, %0d refused on full, %0d clears",
               commands_sent, threshold_writes, creates_seen, refusals_seen, clears_seen);
      $display("Checked %0d results, %0d of them with a saturated miss count.",
               results_checked, saturations_seen);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatch_count,
                  expected_status.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
